FILE: src/rldiu_pkg.sv
// ----------------------------------------------------------------------------
// rldiu_pkg
// Shared types and codes for the run/delta sorted list merge block.
// ----------------------------------------------------------------------------
package rldiu_pkg;

   localparam int unsigned WordWidth = 32;
   localparam int unsigned RunWidth  = 31;

   typedef enum logic [1:0] {
      PH_WORD  = 2'd0,
      PH_DELTA = 2'd1,
      PH_READY = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      MODE_WORD_A  = 2'd0,
      MODE_WORD_B  = 2'd1,
      MODE_STEP    = 2'd2,
      MODE_RESTART = 2'd3
   } mode_type;

   localparam logic [1:0] NEED_NONE = 2'd0;
   localparam logic [1:0] NEED_A    = 2'd1;
   localparam logic [1:0] NEED_B    = 2'd2;

   localparam logic OP_INTERSECT = 1'b0;
   localparam logic OP_UNION     = 1'b1;

   localparam logic [1:0] CSR_OPERATION = 2'd0;
   localparam logic [1:0] CSR_COUNT_A   = 2'd1;
   localparam logic [1:0] CSR_COUNT_B   = 2'd2;

   localparam logic RUN_FLAG = 1'b1;

   typedef struct packed {
      logic [WordWidth-1:0] current;
      logic                 ready;
      logic                 exhausted;
      logic                 can_take;
      logic                 wants_header;
   } list_status_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic advance;
   } list_ctrl_type;

   typedef struct packed {
      logic [WordWidth-1:0] id_out;
      logic                 id_valid;
      logic [1:0]           need;
      logic                 done_res;
      logic                 word_rejected;
   } result_type;

endpackage

FILE: src/rle_delta_list_intersect_unite_top.sv
// ----------------------------------------------------------------------------
// rle_delta_list_intersect_unite_top
// Intersection or union of two sorted run/delta coded id lists.
// ----------------------------------------------------------------------------
// usage
//   req_* carries one item per transfer: a code word for list a or b, a merge
//   step, or a restart. rsp_* returns exactly one result per item, in order.
//   csr_* writes operation (0), count_a (1) and count_b (2); write only while
//   the block is idle.
//   an accepted item is held in the input register, worked through the list
//   logic when the result register is free or being taken, and lands in the
//   result register, where its result is offered.
//   throughput: one item per cycle while no result stalls; list state is
//   written at the same edge as the result register, so the next item sees
//   it at once.
//   a stalled result is held in the result register while the input register
//   still takes one more item; req_stall rises only when both are full.
//   reset clears both valid flags, the config registers and all list state.
// ----------------------------------------------------------------------------
module rle_delta_list_intersect_unite_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_code_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_id_out,
   output logic        rsp_id_valid,
   output logic [1:0]  rsp_need,
   output logic        rsp_done_res,
   output logic        rsp_word_rejected,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data
);

   logic                         operation_ff;
   logic [31:0]                  count_a_ff;
   logic [31:0]                  count_b_ff;

   logic                         in_valid_ff, in_valid_in;
   rldiu_pkg::mode_type          mode_ff;
   logic [31:0]                  word_ff;

   logic                         out_valid_ff, out_valid_in;
   rldiu_pkg::result_type        result_ff;
   rldiu_pkg::result_type        result;

   rldiu_pkg::list_status_type   a_status, b_status;
   rldiu_pkg::list_ctrl_type     a_ctrl, b_ctrl;

   logic                         fire;
   logic                         req_take;

   assign fire     = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !fire;
   assign req_take = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !fire);
   assign out_valid_in = fire || (out_valid_ff && rsp_stall);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         operation_ff <= rldiu_pkg::OP_INTERSECT;
         count_a_ff   <= '0;
         count_b_ff   <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            rldiu_pkg::CSR_OPERATION: operation_ff <= csr_write_data[0];
            rldiu_pkg::CSR_COUNT_A:   count_a_ff   <= csr_write_data;
            rldiu_pkg::CSR_COUNT_B:   count_b_ff   <= csr_write_data;
            default: begin
               operation_ff <= operation_ff;
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         mode_ff <= rldiu_pkg::mode_type'(req_mode);
         word_ff <= req_code_word;
      end
   end

   rldiu_list u_list_a (
      .clock     (clock),
      .reset     (reset),
      .count     (count_a_ff),
      .code_word (word_ff),
      .ctrl      (a_ctrl),
      .status    (a_status)
   );

   rldiu_list u_list_b (
      .clock     (clock),
      .reset     (reset),
      .count     (count_b_ff),
      .code_word (word_ff),
      .ctrl      (b_ctrl),
      .status    (b_status)
   );

   rldiu_step u_step (
      .enable    (fire),
      .mode      (mode_ff),
      .code_word (word_ff),
      .operation (operation_ff),
      .a_status  (a_status),
      .b_status  (b_status),
      .a_ctrl    (a_ctrl),
      .b_ctrl    (b_ctrl),
      .result    (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         result_ff <= result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_id_out        = result_ff.id_out;
   assign rsp_id_valid      = result_ff.id_valid;
   assign rsp_need          = result_ff.need;
   assign rsp_done_res      = result_ff.done_res;
   assign rsp_word_rejected = result_ff.word_rejected;

endmodule

FILE: src/rldiu_list.sv
// ----------------------------------------------------------------------------
// rldiu_list
// State of one coded list: head id, run delta, run length, phase, ids taken.
// ----------------------------------------------------------------------------
module rldiu_list (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [rldiu_pkg::WordWidth-1:0]      count,
   input  logic [rldiu_pkg::WordWidth-1:0]      code_word,
   input  rldiu_pkg::list_ctrl_type             ctrl,
   output rldiu_pkg::list_status_type           status
);

   logic [rldiu_pkg::WordWidth-1:0] current_ff, current_in;
   logic [rldiu_pkg::WordWidth-1:0] delta_ff, delta_in;
   logic [rldiu_pkg::RunWidth-1:0]  run_ff, run_in;
   rldiu_pkg::phase_type            phase_ff, phase_in;
   logic [rldiu_pkg::WordWidth-1:0] taken_ff, taken_in;

   logic [rldiu_pkg::RunWidth-1:0]  val;
   logic [rldiu_pkg::WordWidth-1:0] val_ext;
   logic [rldiu_pkg::WordWidth-1:0] taken_next;

   assign val        = code_word[rldiu_pkg::WordWidth-1:1];
   assign val_ext    = {1'b0, val};
   assign taken_next = taken_ff + 32'd1;

   assign status.current      = current_ff;
   assign status.ready        = (phase_ff == rldiu_pkg::PH_READY);
   assign status.exhausted    = (taken_ff >= count);
   assign status.can_take     = (taken_ff < count) &&
                                ((phase_ff == rldiu_pkg::PH_WORD) ||
                                 (phase_ff == rldiu_pkg::PH_DELTA));
   assign status.wants_header = (phase_ff == rldiu_pkg::PH_WORD);

   always_comb begin
      current_in = current_ff;
      delta_in   = delta_ff;
      run_in     = run_ff;
      phase_in   = phase_ff;
      taken_in   = taken_ff;
      if (ctrl.clear) begin
         current_in = '0;
         delta_in   = '0;
         run_in     = '0;
         phase_in   = rldiu_pkg::PH_WORD;
         taken_in   = '0;
      end else if (ctrl.load) begin
         if (phase_ff == rldiu_pkg::PH_WORD && code_word[0] == rldiu_pkg::RUN_FLAG) begin
            run_in   = (val == '0) ? '0 : val - 31'd1;
            phase_in = rldiu_pkg::PH_DELTA;
         end else begin
            // plain delta word, or delta word after a run header
            delta_in   = val_ext;
            current_in = current_ff + val_ext;
            if (phase_ff == rldiu_pkg::PH_WORD) begin
               run_in = '0;
            end
            phase_in = rldiu_pkg::PH_READY;
         end
      end else if (ctrl.advance) begin
         taken_in = taken_next;
         if (taken_next < count && run_ff != '0) begin
            current_in = current_ff + delta_ff;
            run_in     = run_ff - 31'd1;
            phase_in   = rldiu_pkg::PH_READY;
         end else begin
            phase_in = rldiu_pkg::PH_WORD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         current_ff <= '0;
         delta_ff   <= '0;
         run_ff     <= '0;
         phase_ff   <= rldiu_pkg::PH_WORD;
         taken_ff   <= '0;
      end else begin
         current_ff <= current_in;
         delta_ff   <= delta_in;
         run_ff     <= run_in;
         phase_ff   <= phase_in;
         taken_ff   <= taken_in;
      end
   end

endmodule

FILE: src/rldiu_step.sv
// ----------------------------------------------------------------------------
// rldiu_step
// Decision logic for one item: word load, merge step or restart.
// ----------------------------------------------------------------------------
module rldiu_step (
   input  logic                             enable,
   input  rldiu_pkg::mode_type              mode,
   input  logic [rldiu_pkg::WordWidth-1:0]  code_word,
   input  logic                             operation,
   input  rldiu_pkg::list_status_type       a_status,
   input  rldiu_pkg::list_status_type       b_status,
   output rldiu_pkg::list_ctrl_type         a_ctrl,
   output rldiu_pkg::list_ctrl_type         b_ctrl,
   output rldiu_pkg::result_type            result
);

   rldiu_pkg::list_ctrl_type a_sel, b_sel;
   logic                     is_union;

   assign is_union = (operation == rldiu_pkg::OP_UNION);

   always_comb begin
      a_sel  = '0;
      b_sel  = '0;
      result = '0;
      case (mode)
         rldiu_pkg::MODE_WORD_A: begin
            if (a_status.can_take) begin
               a_sel.load = 1'b1;
               if (a_status.wants_header && code_word[0] == rldiu_pkg::RUN_FLAG) begin
                  result.need = rldiu_pkg::NEED_A;
               end
            end else begin
               result.word_rejected = 1'b1;
            end
         end
         rldiu_pkg::MODE_WORD_B: begin
            if (b_status.can_take) begin
               b_sel.load = 1'b1;
               if (b_status.wants_header && code_word[0] == rldiu_pkg::RUN_FLAG) begin
                  result.need = rldiu_pkg::NEED_B;
               end
            end else begin
               result.word_rejected = 1'b1;
            end
         end
         rldiu_pkg::MODE_RESTART: begin
            a_sel.clear = 1'b1;
            b_sel.clear = 1'b1;
         end
         rldiu_pkg::MODE_STEP: begin
            if (!is_union && (a_status.exhausted || b_status.exhausted)) begin
               result.done_res = 1'b1;
            end else if (a_status.exhausted && b_status.exhausted) begin
               result.done_res = 1'b1;
            end else if (a_status.exhausted) begin
               if (!b_status.ready) begin
                  result.need = rldiu_pkg::NEED_B;
               end else begin
                  result.id_out   = b_status.current;
                  result.id_valid = 1'b1;
                  b_sel.advance   = 1'b1;
               end
            end else if (b_status.exhausted) begin
               if (!a_status.ready) begin
                  result.need = rldiu_pkg::NEED_A;
               end else begin
                  result.id_out   = a_status.current;
                  result.id_valid = 1'b1;
                  a_sel.advance   = 1'b1;
               end
            end else if (!a_status.ready) begin
               result.need = rldiu_pkg::NEED_A;
            end else if (!b_status.ready) begin
               result.need = rldiu_pkg::NEED_B;
            end else if (a_status.current == b_status.current) begin
               result.id_out   = a_status.current;
               result.id_valid = 1'b1;
               a_sel.advance   = 1'b1;
               b_sel.advance   = 1'b1;
            end else if (a_status.current < b_status.current) begin
               if (is_union) begin
                  result.id_out   = a_status.current;
                  result.id_valid = 1'b1;
               end
               a_sel.advance = 1'b1;
            end else begin
               if (is_union) begin
                  result.id_out   = b_status.current;
                  result.id_valid = 1'b1;
               end
               b_sel.advance = 1'b1;
            end
         end
         default: begin
            result = '0;
         end
      endcase
   end

   assign a_ctrl = enable ? a_sel : '0;
   assign b_ctrl = enable ? b_sel : '0;

endmodule

FILE: bench/merge_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// merge_result_checker
// Watches the item and result channels of the run/delta list merge block,
// keeps its own copy of both list decoders and the config registers, works
// out the result of every accepted item and compares each result transfer
// field by field with the oldest one still waiting. Also tells the stimulus
// side which list waits for a word and whether the merge is over.
// ----------------------------------------------------------------------------
module merge_result_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_code_word,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_id_out,
   input  logic        rsp_id_valid,
   input  logic [1:0]  rsp_need,
   input  logic        rsp_done_res,
   input  logic        rsp_word_rejected,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data,
   output int          error_count,
   output int          pending,
   output int          results_checked,
   output int          ids_emitted,
   output logic [1:0]  list_hungry,
   output logic        merge_finished
);

   typedef struct {
      logic [31:0]          head;
      logic [31:0]          stride;
      logic [30:0]          run_left;
      rldiu_pkg::phase_type phase;
      logic [31:0]          taken;
   } list_track_type;

   list_track_type         lists [2];
   logic [31:0]            id_count [2];
   logic                   op_select;
   rldiu_pkg::result_type  pending_results [$];

   function automatic logic exhausted(int x);
      return lists[x].taken >= id_count[x];
   endfunction

   function automatic void clear_lists();
      for (int x = 0; x < 2; x++) begin
         lists[x].head     = '0;
         lists[x].stride   = '0;
         lists[x].run_left = '0;
         lists[x].phase    = rldiu_pkg::PH_WORD;
         lists[x].taken    = '0;
      end
   endfunction

   function automatic logic feed_word(int x, logic [31:0] word);
      logic [30:0] value;
      value = word[31:1];
      if (exhausted(x) || lists[x].phase == rldiu_pkg::PH_READY) return 1'b0;
      if (lists[x].phase == rldiu_pkg::PH_WORD && word[0] == rldiu_pkg::RUN_FLAG) begin
         lists[x].run_left = (value == '0) ? '0 : value - 31'd1;
         lists[x].phase    = rldiu_pkg::PH_DELTA;
         return 1'b1;
      end
      if (lists[x].phase == rldiu_pkg::PH_WORD) lists[x].run_left = '0;
      lists[x].stride = {1'b0, value};
      lists[x].head   = lists[x].head + {1'b0, value};
      lists[x].phase  = rldiu_pkg::PH_READY;
      return 1'b1;
   endfunction

   function automatic void advance_list(int x);
      lists[x].taken = lists[x].taken + 32'd1;
      if (lists[x].taken < id_count[x] && lists[x].run_left != '0) begin
         lists[x].head     = lists[x].head + lists[x].stride;
         lists[x].run_left = lists[x].run_left - 31'd1;
         lists[x].phase    = rldiu_pkg::PH_READY;
      end else begin
         lists[x].phase = rldiu_pkg::PH_WORD;
      end
   endfunction

   function automatic void emit_head(inout rldiu_pkg::result_type r, input int x);
      r.id_out   = lists[x].head;
      r.id_valid = 1'b1;
   endfunction

   function automatic rldiu_pkg::result_type next_result(rldiu_pkg::mode_type mode,
                                                         logic [31:0] word);
      rldiu_pkg::result_type r;
      logic                  a_ex, b_ex, a_rdy, b_rdy;
      r = '0;
      case (mode)
         rldiu_pkg::MODE_WORD_A: begin
            if (feed_word(0, word))
               r.need = (lists[0].phase == rldiu_pkg::PH_DELTA) ? rldiu_pkg::NEED_A
                                                                : rldiu_pkg::NEED_NONE;
            else r.word_rejected = 1'b1;
         end
         rldiu_pkg::MODE_WORD_B: begin
            if (feed_word(1, word))
               r.need = (lists[1].phase == rldiu_pkg::PH_DELTA) ? rldiu_pkg::NEED_B
                                                                : rldiu_pkg::NEED_NONE;
            else r.word_rejected = 1'b1;
         end
         rldiu_pkg::MODE_RESTART: begin
            clear_lists();
         end
         default: begin
            a_ex  = exhausted(0);
            b_ex  = exhausted(1);
            a_rdy = lists[0].phase == rldiu_pkg::PH_READY;
            b_rdy = lists[1].phase == rldiu_pkg::PH_READY;
            if (op_select == rldiu_pkg::OP_INTERSECT && (a_ex || b_ex)) begin
               r.done_res = 1'b1;
            end else if (a_ex && b_ex) begin
               r.done_res = 1'b1;
            end else if (a_ex) begin
               if (!b_rdy) r.need = rldiu_pkg::NEED_B;
               else begin
                  emit_head(r, 1);
                  advance_list(1);
               end
            end else if (b_ex) begin
               if (!a_rdy) r.need = rldiu_pkg::NEED_A;
               else begin
                  emit_head(r, 0);
                  advance_list(0);
               end
            end else if (!a_rdy) begin
               r.need = rldiu_pkg::NEED_A;
            end else if (!b_rdy) begin
               r.need = rldiu_pkg::NEED_B;
            end else if (lists[0].head == lists[1].head) begin
               emit_head(r, 0);
               advance_list(0);
               advance_list(1);
            end else if (lists[0].head < lists[1].head) begin
               if (op_select == rldiu_pkg::OP_UNION) emit_head(r, 0);
               advance_list(0);
            end else begin
               if (op_select == rldiu_pkg::OP_UNION) emit_head(r, 1);
               advance_list(1);
            end
         end
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      if (error_count <= 40)
         $display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
   endtask

   always @(posedge clock) begin : watch
      rldiu_pkg::result_type got, want;
      if (reset) begin
         clear_lists();
         id_count[0]     = '0;
         id_count[1]     = '0;
         op_select       = rldiu_pkg::OP_INTERSECT;
         error_count     = 0;
         results_checked = 0;
         ids_emitted     = 0;
         pending_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_id_out, rsp_id_valid, rsp_need, rsp_done_res, rsp_word_rejected};
            if (pending_results.size() == 0) begin
               report_mismatch("result with nothing expected", got.id_out, '0);
            end else begin
               want = pending_results.pop_front();
               if (got.id_out !== want.id_out) report_mismatch("id_out", got.id_out, want.id_out);
               if (got.id_valid !== want.id_valid)
                  report_mismatch("id_valid", 32'(got.id_valid), 32'(want.id_valid));
               if (got.need !== want.need)
                  report_mismatch("need", 32'(got.need), 32'(want.need));
               if (got.done_res !== want.done_res)
                  report_mismatch("done_res", 32'(got.done_res), 32'(want.done_res));
               if (got.word_rejected !== want.word_rejected)
                  report_mismatch("word_rejected", 32'(got.word_rejected),
                                  32'(want.word_rejected));
               results_checked++;
               if (want.id_valid) ids_emitted++;
            end
         end
         if (csr_write_enable) begin
            case (csr_index)
               rldiu_pkg::CSR_OPERATION: op_select   = csr_write_data[0];
               rldiu_pkg::CSR_COUNT_A:   id_count[0] = csr_write_data;
               rldiu_pkg::CSR_COUNT_B:   id_count[1] = csr_write_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            pending_results.insert(pending_results.size(),
               next_result(rldiu_pkg::mode_type'(req_mode), req_code_word));
      end
      pending        = pending_results.size();
      list_hungry[0] = !exhausted(0) && lists[0].phase != rldiu_pkg::PH_READY;
      list_hungry[1] = !exhausted(1) && lists[1].phase != rldiu_pkg::PH_READY;
      merge_finished = (op_select == rldiu_pkg::OP_UNION) ? (exhausted(0) && exhausted(1))
                                                          : (exhausted(0) || exhausted(1));
   end

endmodule

FILE: bench/rle_delta_list_intersect_unite_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rle_delta_list_intersect_unite_top_tb
// Drives the run/delta list merge block with a short directed sequence and
// then with random merge sessions: each session sets operation and list
// sizes while the block is idle, restarts, and mostly feeds code words to
// the list that waits for one, mixed with merge steps and noise. Both sides
// idle and stall at random in several phases; the checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
module rle_delta_list_intersect_unite_top_tb;

   localparam int ItemTarget = 1150;
   localparam int IdleLimit  = 5000;

   logic        clock;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic [1:0]  req_mode         = '0;
   logic [31:0] req_code_word    = '0;
   logic        rsp_stall        = 1'b0;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index        = '0;
   logic [31:0] csr_write_data   = '0;

   logic        req_stall;
   logic        rsp_valid;
   logic [31:0] rsp_id_out;
   logic        rsp_id_valid;
   logic [1:0]  rsp_need;
   logic        rsp_done_res;
   logic        rsp_word_rejected;

   int          error_count;
   int          pending;
   int          results_checked;
   int          ids_emitted;
   logic [1:0]  list_hungry;
   logic        merge_finished;

   int          idle_pct     = 0;
   int          stall_pct    = 0;
   int          items_sent   = 0;
   int          sessions     = 0;
   int          quiet_cycles = 0;

   rle_delta_list_intersect_unite_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_code_word     (req_code_word),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_id_out        (rsp_id_out),
      .rsp_id_valid      (rsp_id_valid),
      .rsp_need          (rsp_need),
      .rsp_done_res      (rsp_done_res),
      .rsp_word_rejected (rsp_word_rejected),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   merge_result_checker merge_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_code_word     (req_code_word),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_id_out        (rsp_id_out),
      .rsp_id_valid      (rsp_id_valid),
      .rsp_need          (rsp_need),
      .rsp_done_res      (rsp_done_res),
      .rsp_word_rejected (rsp_word_rejected),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .error_count       (error_count),
      .pending           (pending),
      .results_checked   (results_checked),
      .ids_emitted       (ids_emitted),
      .list_hungry       (list_hungry),
      .merge_finished    (merge_finished)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // no transfer on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IdleLimit) begin
         $display("rle_delta_list_intersect_unite_top_tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // called right after a falling edge; returns at the edge of the transfer
   task automatic drive_item(input rldiu_pkg::mode_type m, input logic [31:0] w);
      case (items_sent * 4 / ItemTarget)
         0:       begin idle_pct = 0;  stall_pct = 0;  end
         1:       begin idle_pct = 62; stall_pct = 0;  end
         2:       begin idle_pct = 0;  stall_pct = 62; end
         default: begin idle_pct = 19; stall_pct = 19; end
      endcase
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_mode      <= m;
      req_code_word <= w;
      items_sent++;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic issue(input rldiu_pkg::mode_type m, input logic [31:0] w);
      @(negedge clock);
      drive_item(m, w);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
   endtask

   task automatic start_session(input logic op, input logic [31:0] size_a,
                                input logic [31:0] size_b);
      drain_results();
      write_reg(rldiu_pkg::CSR_OPERATION, {31'b0, op});
      write_reg(rldiu_pkg::CSR_COUNT_A, size_a);
      write_reg(rldiu_pkg::CSR_COUNT_B, size_b);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      sessions++;
      issue(rldiu_pkg::MODE_RESTART, $urandom);
   endtask

   function automatic logic [31:0] random_size();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 5) return '0;
      if (pick < 10) return 32'hFFFF_FFFF;
      if (pick < 20) return $urandom_range(11, 40);
      return $urandom_range(1, 10);
   endfunction

   function automatic logic [31:0] random_word();
      logic [31:0] value;
      int          pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) value = $urandom_range(0, 3);
      else if (pick < 85) value = $urandom_range(0, 100);
      else value = $urandom;
      return {value[30:0], logic'($urandom_range(0, 99) < 30)};
   endfunction

   task automatic run_session();
      int                  budget, done_steps;
      rldiu_pkg::mode_type m;
      logic [31:0]         w;
      budget     = $urandom_range(20, 90);
      done_steps = 0;
      start_session(logic'($urandom_range(0, 1)), random_size(), random_size());
      while (budget > 0 && done_steps < 2 && items_sent < ItemTarget) begin
         @(negedge clock);
         w = random_word();
         if ($urandom_range(0, 99) < 10) begin
            m = ($urandom_range(0, 19) == 0) ? rldiu_pkg::MODE_RESTART
                                             : rldiu_pkg::mode_type'($urandom_range(0, 2));
            w = $urandom;
         end else if (merge_finished) begin
            m = rldiu_pkg::MODE_STEP;
            done_steps++;
         end else if ($urandom_range(0, 99) < 15) begin
            m = rldiu_pkg::MODE_STEP;
         end else if (list_hungry[0]) begin
            m = rldiu_pkg::MODE_WORD_A;
         end else if (list_hungry[1]) begin
            m = rldiu_pkg::MODE_WORD_B;
         end else begin
            m = rldiu_pkg::MODE_STEP;
         end
         drive_item(m, w);
         budget--;
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty lists: done at once, words for exhausted lists bounce
      start_session(rldiu_pkg::OP_INTERSECT, 32'd0, 32'd0);
      issue(rldiu_pkg::MODE_STEP, 32'd0);
      issue(rldiu_pkg::MODE_WORD_A, 32'hFFFF_FFFF);
      issue(rldiu_pkg::MODE_WORD_B, 32'h0000_0002);

      // union with runs, a zero run count, wraparound and a tail from list a
      start_session(rldiu_pkg::OP_UNION, 32'd4, 32'd2);
      issue(rldiu_pkg::MODE_STEP, 32'd0);
      issue(rldiu_pkg::MODE_WORD_A, 32'h0000_0002);
      issue(rldiu_pkg::MODE_STEP, 32'd0);
      issue(rldiu_pkg::MODE_WORD_B, 32'h0000_0001);
      issue(rldiu_pkg::MODE_WORD_B, 32'h0000_0002);
      issue(rldiu_pkg::MODE_WORD_A, 32'h0000_0004);
      issue(rldiu_pkg::MODE_STEP, 32'd0);
      issue(rldiu_pkg::MODE_WORD_A, 32'h0000_0007);
      issue(rldiu_pkg::MODE_WORD_A, 32'hFFFF_FFFE);
      issue(rldiu_pkg::MODE_WORD_B, 32'hFFFF_FFFE);
      repeat (4) issue(rldiu_pkg::MODE_STEP, 32'd0);
      issue(rldiu_pkg::MODE_WORD_A, 32'h0000_0002);

      // largest lists, intersection skipping the smaller head
      start_session(rldiu_pkg::OP_INTERSECT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      issue(rldiu_pkg::MODE_WORD_A, 32'h0000_0004);
      issue(rldiu_pkg::MODE_WORD_B, 32'h0000_0006);
      issue(rldiu_pkg::MODE_STEP, 32'd0);
      issue(rldiu_pkg::MODE_STEP, 32'd0);

      while (items_sent < ItemTarget) run_session();

      drain_results();
      repeat (10) @(posedge clock);
      $display("run covered %0d items over %0d merge sessions", items_sent, sessions);
      $display("%0d results compared, %0d of them carrying an id", results_checked,
               ids_emitted);
      if (error_count == 0 && pending == 0) begin
         $display("rle_delta_list_intersect_unite_top_tb: clean");
      end else begin
         $display("rle_delta_list_intersect_unite_top_tb: errors");
      end
      $finish;
   end

endmodule
